// ----- hdl/pziir_pkg.sv -----
// Shared types and constants for the pole-zero IIR filter.
// No dependencies; imported by the filter top level and its checker.
`timescale 1ns / 1ps

package pziir_pkg;

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 4;
    localparam int COEF_W  = 24;   // signed Q5.18
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = COEF_W + SAMP_W;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SAMP_W-1:0] t_sample;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_NUM    = 2'd1,
        MODE_DEN    = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // Output clip limits
    localparam t_sample SAMP_MAX     = 16'sh7FFF;
    localparam t_sample SAMP_MIN     = 16'sh8000;
    localparam int      POS_LIM_MAG  = 32767;
    localparam int      NEG_LIM_MAG  = 32768;

endpackage

// ----- hdl/pziir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the filter coefficient stores.
`timescale 1ns / 1ps

module pziir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 11,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pole_zero_iir_filter.sv -----
// Direct-form-I pole-zero filter, one shared MAC plus a serial divider.
// Depends on pziir_pkg and pziir_ram.
`timescale 1ns / 1ps

// Mode 0 transactions are filter samples; each produces one result. Modes 1 and 2
// load one numerator or denominator coefficient (index above ORDER is dropped),
// mode 3 clears both sample histories; these leave o_stall low and give no result.
// For a sample, one 24x16 multiplier walks the 2*ORDER+1 taps one per cycle
// through a three-stage read/multiply/accumulate pipe, then a restoring divider
// retires one quotient bit per cycle over the ACC_W-bit sum. A zero leading
// denominator skips the divide. o_stall is high for the whole sample; a finished
// result may wait in the output register while the next transaction is taken.
// Coefficients reset to zero through per-entry valid bits, so there is no
// clearing pass.

module pole_zero_iir_filter
    import pziir_pkg::*;
#(
    parameter int ORDER = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample / command channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [IDX_W-1:0]        i_coef_index,
    input  logic signed [COEF_W-1:0] i_coef_value,
    input  logic signed [SAMP_W-1:0] i_sample_in,
    input  logic                    i_frame_end,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SAMP_W-1:0] o_sample_out,
    output logic                    o_saturated,
    output logic                    o_divide_error,
    output logic                    o_last_of_frame
);

    localparam int NCOEF  = ORDER + 1;
    localparam int AW     = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int HW     = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int CMP_W  = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int ACC_W  = PROD_W + $clog2(2 * ORDER + 1);
    localparam int DCNT_W = $clog2(ACC_W + 1);
    localparam int REM_W  = COEF_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_DRAIN, S_ABS, S_DIV, S_SAT, S_OUT
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_k;
    logic                    r_den_ph;
    logic [AW-1:0]           w_km1;

    logic [ORDER:0]          r_num_vld;
    logic [ORDER:0]          r_den_vld;
    t_coef                   r_a0;
    t_sample                 r_xh [ORDER];
    t_sample                 r_yh [ORDER];
    t_sample                 r_x;
    logic                    r_last;

    // MAC pipe
    logic                    r_a_vld, r_a_den, r_a_ok;
    t_sample                 r_a_opnd;
    logic                    r_b_vld, r_b_sub;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_coef                   w_coef;

    // divider
    logic [ACC_W-1:0]        r_quo;
    logic [REM_W-1:0]        r_rem;
    logic [COEF_W-1:0]       r_dvs;
    logic                    r_neg;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [REM_W:0]          w_trial;
    logic [REM_W:0]          w_diff;
    logic                    w_ge;

    t_sample                 r_y;
    logic                    r_sat, r_derr;

    logic                    r_out_vld;
    t_sample                 r_out_sample;
    logic                    r_out_sat, r_out_derr, r_out_last;

    // input decode
    logic                    w_acc_in;
    logic [CMP_W-1:0]        w_idx_ext;
    logic                    w_idx_ok;
    logic [AW-1:0]           w_waddr;
    logic                    w_num_we, w_den_we;
    t_coef                   w_num_rd, w_den_rd;

    assign o_stall   = (r_state != S_IDLE);
    assign w_acc_in  = i_valid && !o_stall;
    assign w_idx_ext = CMP_W'(i_coef_index);
    assign w_idx_ok  = (w_idx_ext <= CMP_W'(ORDER));
    assign w_waddr   = AW'(w_idx_ext);
    assign w_num_we  = w_acc_in && (t_mode'(i_mode) == MODE_NUM) && w_idx_ok;
    assign w_den_we  = w_acc_in && (t_mode'(i_mode) == MODE_DEN) && w_idx_ok;
    assign w_km1     = r_k - AW'(1);

    pziir_ram #(.WIDTH(COEF_W), .DEPTH(NCOEF)) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (w_num_we),
        .i_waddr (w_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (r_k),
        .o_rdata (w_num_rd)
    );

    pziir_ram #(.WIDTH(COEF_W), .DEPTH(NCOEF)) u_den_ram (
        .i_clk   (i_clk),
        .i_we    (w_den_we),
        .i_waddr (w_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (r_k),
        .o_rdata (w_den_rd)
    );

    // coefficient that reaches the multiplier; unwritten entries read as zero
    always_comb begin
        if (!r_a_ok) begin
            w_coef = '0;
        end else if (r_a_den) begin
            w_coef = w_den_rd;
        end else begin
            w_coef = w_num_rd;
        end
    end

    // one restoring divide step on magnitudes
    assign w_trial = {r_rem, r_quo[ACC_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_num_vld <= '0;
            r_den_vld <= '0;
            r_a0      <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_k       <= '0;
            r_den_ph  <= 1'b0;
            for (int i = 0; i < ORDER; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else begin
            // result leaves when taken, unless a new one replaces it
            if (r_out_vld && !i_stall && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end

            // MAC stages: multiply, then accumulate
            r_b_vld <= r_a_vld;
            r_b_sub <= r_a_den;
            r_prod  <= w_coef * r_a_opnd;
            if (r_b_vld) begin
                if (r_b_sub) begin
                    r_acc <= r_acc - ACC_W'(r_prod);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            r_a_vld <= (r_state == S_MAC);

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        unique case (t_mode'(i_mode))
                            MODE_SAMPLE: begin
                                r_x      <= i_sample_in;
                                r_last   <= i_frame_end;
                                r_acc    <= '0;
                                r_k      <= '0;
                                r_den_ph <= 1'b0;
                                r_state  <= S_MAC;
                            end
                            MODE_NUM: begin
                                if (w_idx_ok) begin
                                    r_num_vld[w_waddr] <= 1'b1;
                                end
                            end
                            MODE_DEN: begin
                                if (w_idx_ok) begin
                                    r_den_vld[w_waddr] <= 1'b1;
                                    if (w_waddr == '0) begin
                                        r_a0 <= i_coef_value;
                                    end
                                end
                            end
                            MODE_CLEAR: begin
                                for (int i = 0; i < ORDER; i++) begin
                                    r_xh[i] <= '0;
                                    r_yh[i] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // issue one tap per cycle: b0*x, then b_k*x[n-k], a_k*y[n-k]
                S_MAC: begin
                    r_a_den <= r_den_ph;
                    if (r_den_ph) begin
                        r_a_ok   <= r_den_vld[r_k];
                        r_a_opnd <= r_yh[w_km1[HW-1:0]];
                    end else begin
                        r_a_ok   <= r_num_vld[r_k];
                        r_a_opnd <= (r_k == '0) ? r_x : r_xh[w_km1[HW-1:0]];
                    end
                    if (r_den_ph) begin
                        r_den_ph <= 1'b0;
                        if (r_k == AW'(ORDER)) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_k <= r_k + AW'(1);
                        end
                    end else if (r_k == '0) begin
                        r_k <= AW'(1);
                    end else begin
                        r_den_ph <= 1'b1;
                    end
                end

                S_DRAIN: begin
                    if (!r_a_vld && !r_b_vld) begin
                        if (r_a0 == '0) begin
                            r_y     <= '0;
                            r_sat   <= 1'b0;
                            r_derr  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ABS;
                        end
                    end
                end

                // operand magnitudes and quotient sign
                S_ABS: begin
                    r_quo  <= r_acc[ACC_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
                    r_dvs  <= r_a0[COEF_W-1] ? $unsigned(-r_a0) : $unsigned(r_a0);
                    r_neg  <= r_acc[ACC_W-1] ^ r_a0[COEF_W-1];
                    r_rem  <= '0;
                    r_dcnt <= DCNT_W'(ACC_W);
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
                    r_quo  <= {r_quo[ACC_W-2:0], w_ge};
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        r_state <= S_SAT;
                    end
                end

                // truncated quotient, clipped to 16 bits
                S_SAT: begin
                    r_derr <= 1'b0;
                    if (!r_neg && (r_quo > ACC_W'(POS_LIM_MAG))) begin
                        r_y   <= SAMP_MAX;
                        r_sat <= 1'b1;
                    end else if (r_neg && (r_quo > ACC_W'(NEG_LIM_MAG))) begin
                        r_y   <= SAMP_MIN;
                        r_sat <= 1'b1;
                    end else if (r_neg) begin
                        r_y   <= -$signed(r_quo[SAMP_W-1:0]);
                        r_sat <= 1'b0;
                    end else begin
                        r_y   <= $signed(r_quo[SAMP_W-1:0]);
                        r_sat <= 1'b0;
                    end
                    r_state <= S_OUT;
                end

                // hand over result and shift histories
                S_OUT: begin
                    if (!r_out_vld || !i_stall) begin
                        r_out_vld    <= 1'b1;
                        r_out_sample <= r_y;
                        r_out_sat    <= r_sat;
                        r_out_derr   <= r_derr;
                        r_out_last   <= r_last;
                        for (int i = ORDER - 1; i > 0; i--) begin
                            r_xh[i] <= r_xh[i-1];
                            r_yh[i] <= r_yh[i-1];
                        end
                        r_xh[0] <= r_x;
                        r_yh[0] <= r_y;
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_vld;
    assign o_sample_out    = r_out_sample;
    assign o_saturated     = r_out_sat;
    assign o_divide_error  = r_out_derr;
    assign o_last_of_frame = r_out_last;

endmodule

// ----- hdl/pziir_checker.sv -----
// Port-level checks for pole_zero_iir_filter, attached by bind.
// Depends on pziir_pkg.
`timescale 1ns / 1ps

module pziir_assertions
    import pziir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic signed [SAMP_W-1:0] o_sample_out,
    input  logic                     o_saturated,
    input  logic                     o_divide_error
);

    // a held result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_out))
        else $error("result dropped or changed while stalled");

    // a zero leading denominator forces a clean zero
    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> (o_sample_out == '0) && !o_saturated)
        else $error("divide error with nonzero output or saturation");

    // clipping lands on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (o_sample_out == SAMP_MAX) || (o_sample_out == SAMP_MIN))
        else $error("saturated output not at a limit");

    // a sample keeps the block busy
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (t_mode'(i_mode) == MODE_SAMPLE) |=> o_stall)
        else $error("not busy after sample transaction");

    // commands do not make the block busy
    a_cmd_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (t_mode'(i_mode) != MODE_SAMPLE) |=> !o_stall)
        else $error("busy after command transaction");

endmodule

bind pole_zero_iir_filter pziir_assertions u_pziir_assertions (.*);
